@@ src/dgr_pkg.sv @@
package dgr_pkg;

   // field and register widths
   localparam int GAIN_W      = 16;
   localparam int RAMP_W      = 20;
   localparam int CSR_DATA_W  = 20;
   localparam int CSR_INDEX_W = 2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_GAIN  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAMP_SAMPLES = 2'd1;

   // ramp arithmetic: step is dB Q8.8 per sample in Q15
   localparam int                STEP_FRAC   = 15;
   localparam int                DIVIDEND_W  = GAIN_W + STEP_FRAC;
   localparam int                RAMP_PROD_W = DIVIDEND_W + RAMP_W;
   localparam int                OM_W        = RAMP_PROD_W + 1 - STEP_FRAC;
   localparam logic [RAMP_W-1:0] POS_MAX     = {RAMP_W{1'b1}};

   // shared multiplier
   localparam int MUL_W  = 32;
   localparam int PROD_W = 2 * MUL_W;

   // log2 domain: L = g * log2(10)/20 (Q28) gives Q36, biased by 32 << 36
   localparam int                LOG_C_W             = 26;
   localparam logic [LOG_C_W-1:0] LOG2_10_OVER_20_Q28 = 26'd44586164;
   localparam int                LOG_W               = 42;
   localparam int                LOG_FRAC_W          = 36;
   localparam logic [LOG_W-1:0]  EXP_BIAS            = LOG_W'(1) << (LOG_W - 1);
   localparam int                FRAC_MSB            = LOG_FRAC_W - 1;
   localparam int                FRAC_LSB            = 16;
   localparam int                FRAC_W              = FRAC_MSB - FRAC_LSB + 1;
   localparam int                EXP_CODE_W          = LOG_W - LOG_FRAC_W;
   localparam logic [EXP_CODE_W-1:0] SHIFT_BASE      = 6'd62;

   // 2^x table, Q30, with one guard entry for interpolation
   localparam int   GAIN_TABLE_DEPTH = 256;
   localparam int   TABLE_INDEX_W    = $clog2(GAIN_TABLE_DEPTH);
   localparam int   TABLE_ADDR_W     = TABLE_INDEX_W + 1;
   localparam int   TABLE_W          = 32;
   localparam int   MANT_FRAC        = 30;
   localparam int   SERIES_TERMS     = 20;
   localparam logic [63:0] LN2_Q30   = 64'd744261118;

   typedef logic [TABLE_W-1:0] pow2_table_type [0:GAIN_TABLE_DEPTH];

   // multiplier operand select
   typedef logic [1:0] mul_sel_type;
   localparam mul_sel_type MUL_SEL_RAMP   = 2'd0;
   localparam mul_sel_type MUL_SEL_LOG    = 2'd1;
   localparam mul_sel_type MUL_SEL_INTERP = 2'd2;
   localparam mul_sel_type MUL_SEL_SCALE  = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic        accept;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        gain_update;
      logic        exp_load;
      logic        table_load;
      logic        mant_load;
      logic        round_load;
      logic        out_load;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_busy;
      logic ramp_active;
      logic present;
      logic out_free;
   } ctrl_status_type;

   // series term divided by its index
   function automatic logic [63:0] div_by_term(input logic [63:0] v, input int n);
      logic [63:0] q;
      case (n)
         1:       q = v;
         2:       q = v / 2;
         3:       q = v / 3;
         4:       q = v / 4;
         5:       q = v / 5;
         6:       q = v / 6;
         7:       q = v / 7;
         8:       q = v / 8;
         9:       q = v / 9;
         10:      q = v / 10;
         11:      q = v / 11;
         12:      q = v / 12;
         13:      q = v / 13;
         14:      q = v / 14;
         15:      q = v / 15;
         16:      q = v / 16;
         17:      q = v / 17;
         18:      q = v / 18;
         19:      q = v / 19;
         20:      q = v / 20;
         default: q = v;
      endcase
      return q;
   endfunction

   // 2^(i/depth) by exp series on i/depth * ln2, evaluated at elaboration
   function automatic pow2_table_type build_pow2_table();
      pow2_table_type t;
      logic [63:0]    x;
      logic [63:0]    y;
      logic [63:0]    term;
      logic [63:0]    sum;
      for (int i = 0; i <= GAIN_TABLE_DEPTH; i++) begin
         x    = 64'(i) << (MANT_FRAC - TABLE_INDEX_W);
         y    = (x * LN2_Q30) >> MANT_FRAC;
         term = 64'd1 << MANT_FRAC;
         sum  = term;
         for (int n = 1; n <= SERIES_TERMS; n++) begin
            term = div_by_term((term * y) >> MANT_FRAC, n);
            sum  = sum + term;
         end
         t[i] = sum[TABLE_W-1:0];
      end
      return t;
   endfunction

   localparam pow2_table_type POW2_TABLE = build_pow2_table();

endpackage

@@ src/dgr_div.sv @@
module dgr_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [dgr_pkg::DIVIDEND_W-1:0]  dividend,
   input  logic [dgr_pkg::RAMP_W-1:0]      divisor,
   output logic                            busy,
   output logic                            done,
   output logic [dgr_pkg::DIVIDEND_W-1:0]  quotient
);
   import dgr_pkg::*;

   localparam int COUNT_W = $clog2(DIVIDEND_W);

   logic [COUNT_W-1:0]    count_ff, count_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [RAMP_W-1:0]     rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [RAMP_W-1:0]     divisor_ff, divisor_in;
   logic [RAMP_W:0]       trial;
   logic [RAMP_W:0]       trial_diff;
   logic                  fits;

   // one quotient bit per cycle, restoring
   always_comb begin
      trial      = {rem_ff, quo_ff[DIVIDEND_W-1]};
      trial_diff = trial - {1'b0, divisor_ff};
      fits       = trial >= {1'b0, divisor_ff};
      count_in   = count_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         count_in   = COUNT_W'(DIVIDEND_W - 1);
         rem_in     = '0;
         quo_in     = dividend;
         divisor_in = divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? trial_diff[RAMP_W-1:0] : trial[RAMP_W-1:0];
         quo_in   = {quo_ff[DIVIDEND_W-2:0], fits};
         count_in = count_ff - 1'b1;
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ src/dgr_datapath.sv @@
module dgr_datapath #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [SAMPLE_BITS-1:0]            req_sample_in,
   input  logic                              req_sample_present,
   input  logic                              rsp_stall,
   output logic                              rsp_valid,
   output logic [SAMPLE_BITS-1:0]            rsp_sample_out,
   output logic                              rsp_ramping,
   input  logic                              csr_write_en,
   input  logic [dgr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [dgr_pkg::CSR_DATA_W-1:0]    csr_write_data,
   input  dgr_pkg::ctrl_cmd_type             cmd,
   output dgr_pkg::ctrl_status_type          status
);
   import dgr_pkg::*;

   localparam int SUM_W = PROD_W + 1;

   // gain and ramp state
   logic [GAIN_W-1:0]     tgt_ff, tgt_in;
   logic [GAIN_W-1:0]     cur_ff, cur_in;
   logic [GAIN_W-1:0]     start_ff, start_in;
   logic [RAMP_W-1:0]     ramp_len_ff, ramp_len_in;
   logic [RAMP_W-1:0]     pos_ff, pos_in;
   logic [DIVIDEND_W-1:0] step_mag_ff, step_mag_in;
   logic                  step_neg_ff, step_neg_in;
   logic [GAIN_W-1:0]     diff_mag_ff, diff_mag_in;

   // per request working registers
   logic [SAMPLE_BITS-1:0] sabs_ff, sabs_in;
   logic                   sneg_ff, sneg_in;
   logic                   present_ff, present_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic [LOG_W-1:0]       u_ff, u_in;
   logic [TABLE_W-1:0]     lo_ff, lo_in;
   logic [TABLE_W-1:0]     delta_ff, delta_in;
   logic [TABLE_W-1:0]     mant_ff, mant_in;
   logic [SAMPLE_BITS-1:0] r_ff, r_in;
   logic                   over_ff, over_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] rsp_sample_ff, rsp_sample_in;
   logic                   rsp_ramping_ff, rsp_ramping_in;

   // combinational terms
   logic [GAIN_W-1:0]     new_tgt;
   logic [GAIN_W:0]       diff;
   logic [GAIN_W:0]       diff_abs;
   logic                  div_start;
   logic                  div_busy;
   logic                  div_done;
   logic [DIVIDEND_W-1:0] div_quotient;
   logic [RAMP_W-1:0]     pos_inc;
   logic [RAMP_PROD_W:0]  om_sum;
   logic [OM_W-1:0]       om;
   logic                  ramp_end;
   logic [GAIN_W-1:0]     ramp_gain;
   logic [GAIN_W-1:0]     gain_abs;
   logic [MUL_W-1:0]      mul_a;
   logic [MUL_W-1:0]      mul_b;
   logic [TABLE_INDEX_W-1:0] tab_idx;
   logic [TABLE_ADDR_W-1:0]  lo_addr;
   logic [TABLE_ADDR_W-1:0]  hi_addr;
   logic [FRAC_W-1:0]        interp_w;
   logic [EXP_CODE_W-1:0]    shift_amt;
   logic [SUM_W-1:0]         round_half;
   logic [SUM_W-1:0]         round_sum;
   logic [SUM_W-1:0]         round_shifted;
   logic [SAMPLE_BITS-1:0]   sat_pos;
   logic [SAMPLE_BITS-1:0]   sat_neg;
   logic [SAMPLE_BITS-1:0]   sample_sat;
   logic                     out_free;

   // step = |target - start| << 15 / ramp length
   dgr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({diff_abs[GAIN_W-1:0], {STEP_FRAC{1'b0}}}),
      .divisor  (ramp_len_ff),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // register write decode
   always_comb begin
      new_tgt   = csr_write_data[GAIN_W-1:0];
      diff      = {new_tgt[GAIN_W-1], new_tgt} - {cur_ff[GAIN_W-1], cur_ff};
      diff_abs  = diff[GAIN_W] ? (~diff + 1'b1) : diff;
      div_start = csr_write_en && (csr_index == CSR_TARGET_GAIN) && (ramp_len_ff != '0);
   end

   // ramp offset and gain update
   always_comb begin
      pos_inc   = (pos_ff == POS_MAX) ? pos_ff : pos_ff + 1'b1;
      om_sum    = {1'b0, prod_ff[RAMP_PROD_W-1:0]} + (RAMP_PROD_W+1)'(1 << (STEP_FRAC - 1));
      om        = om_sum[RAMP_PROD_W:STEP_FRAC];
      ramp_end  = (pos_ff >= ramp_len_ff) || (om >= OM_W'(diff_mag_ff));
      ramp_gain = step_neg_ff ? start_ff - om[GAIN_W-1:0] : start_ff + om[GAIN_W-1:0];
      gain_abs  = cur_ff[GAIN_W-1] ? (~cur_ff + 1'b1) : cur_ff;
   end

   // shared multiplier operand select
   always_comb begin
      unique case (cmd.mul_sel)
         MUL_SEL_RAMP: begin
            mul_a = MUL_W'(step_mag_ff);
            mul_b = MUL_W'(pos_ff);
         end
         MUL_SEL_LOG: begin
            mul_a = MUL_W'(gain_abs);
            mul_b = MUL_W'(LOG2_10_OVER_20_Q28);
         end
         MUL_SEL_INTERP: begin
            mul_a = delta_ff;
            mul_b = MUL_W'(interp_w);
         end
         MUL_SEL_SCALE: begin
            mul_a = MUL_W'(sabs_ff);
            mul_b = mant_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // table addressing, rounding shift and saturation
   always_comb begin
      tab_idx       = u_ff[FRAC_MSB -: TABLE_INDEX_W];
      lo_addr       = {1'b0, tab_idx};
      hi_addr       = lo_addr + 1'b1;
      interp_w      = {u_ff[FRAC_MSB-TABLE_INDEX_W:FRAC_LSB], {TABLE_INDEX_W{1'b0}}};
      shift_amt     = SHIFT_BASE - u_ff[LOG_W-1:LOG_FRAC_W];
      round_half    = SUM_W'(1) << (shift_amt - 1'b1);
      round_sum     = {1'b0, prod_ff} + round_half;
      round_shifted = round_sum >> shift_amt;
      sat_pos       = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      sat_neg       = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      if (!present_ff) begin
         sample_sat = '0;
      end else if (!sneg_ff) begin
         sample_sat = (over_ff || r_ff[SAMPLE_BITS-1]) ? sat_pos : r_ff;
      end else begin
         sample_sat = (over_ff || (r_ff[SAMPLE_BITS-1] && (|r_ff[SAMPLE_BITS-2:0])))
                      ? sat_neg : (~r_ff + 1'b1);
      end
      out_free = !rsp_valid_ff || !rsp_stall;
   end

   // next state of gain, ramp and working registers
   always_comb begin
      tgt_in         = tgt_ff;
      cur_in         = cur_ff;
      start_in       = start_ff;
      ramp_len_in    = ramp_len_ff;
      pos_in         = pos_ff;
      step_mag_in    = step_mag_ff;
      step_neg_in    = step_neg_ff;
      diff_mag_in    = diff_mag_ff;
      sabs_in        = sabs_ff;
      sneg_in        = sneg_ff;
      present_in     = present_ff;
      prod_in        = prod_ff;
      u_in           = u_ff;
      lo_in          = lo_ff;
      delta_in       = delta_ff;
      mant_in        = mant_ff;
      r_in           = r_ff;
      over_in        = over_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_sample_in  = rsp_sample_ff;
      rsp_ramping_in = rsp_ramping_ff;

      // divide result
      if (div_done) begin
         step_mag_in = div_quotient;
      end

      // register writes
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_TARGET_GAIN: begin
               tgt_in      = new_tgt;
               start_in    = cur_ff;
               pos_in      = '0;
               diff_mag_in = diff_abs[GAIN_W-1:0];
               step_neg_in = diff[GAIN_W];
               if (ramp_len_ff == '0) begin
                  cur_in      = new_tgt;
                  step_mag_in = '0;
               end
            end
            CSR_RAMP_SAMPLES: begin
               ramp_len_in = csr_write_data[RAMP_W-1:0];
            end
            default: begin
            end
         endcase
      end

      // request capture and ramp position
      if (cmd.accept) begin
         sabs_in    = req_sample_in[SAMPLE_BITS-1] ? (~req_sample_in + 1'b1) : req_sample_in;
         sneg_in    = req_sample_in[SAMPLE_BITS-1];
         present_in = req_sample_present;
         if (cur_ff != tgt_ff) begin
            pos_in = pos_inc;
         end
      end

      if (cmd.mul_en) begin
         prod_in = mul_a * mul_b;
      end

      if (cmd.gain_update) begin
         cur_in = ramp_end ? tgt_ff : ramp_gain;
      end

      // biased log2 of the linear factor
      if (cmd.exp_load) begin
         u_in = cur_ff[GAIN_W-1] ? EXP_BIAS - prod_ff[LOG_W-1:0]
                                 : EXP_BIAS + prod_ff[LOG_W-1:0];
      end

      if (cmd.table_load) begin
         lo_in    = POW2_TABLE[lo_addr];
         delta_in = POW2_TABLE[hi_addr] - POW2_TABLE[lo_addr];
      end

      if (cmd.mant_load) begin
         mant_in = lo_ff + prod_ff[FRAC_W +: TABLE_W];
      end

      if (cmd.round_load) begin
         r_in    = round_shifted[SAMPLE_BITS-1:0];
         over_in = |round_shifted[SUM_W-1:SAMPLE_BITS];
      end

      if (cmd.out_load) begin
         rsp_valid_in   = 1'b1;
         rsp_sample_in  = sample_sat;
         rsp_ramping_in = cur_ff != tgt_ff;
      end
   end

   // gain and ramp state
   always_ff @(posedge clock) begin
      if (reset) begin
         tgt_ff       <= '0;
         cur_ff       <= '0;
         start_ff     <= '0;
         ramp_len_ff  <= '0;
         pos_ff       <= '0;
         step_mag_ff  <= '0;
         step_neg_ff  <= 1'b0;
         diff_mag_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tgt_ff       <= tgt_in;
         cur_ff       <= cur_in;
         start_ff     <= start_in;
         ramp_len_ff  <= ramp_len_in;
         pos_ff       <= pos_in;
         step_mag_ff  <= step_mag_in;
         step_neg_ff  <= step_neg_in;
         diff_mag_ff  <= diff_mag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and result payload
   always_ff @(posedge clock) begin
      sabs_ff        <= sabs_in;
      sneg_ff        <= sneg_in;
      present_ff     <= present_in;
      prod_ff        <= prod_in;
      u_ff           <= u_in;
      lo_ff          <= lo_in;
      delta_ff       <= delta_in;
      mant_ff        <= mant_in;
      r_ff           <= r_in;
      over_ff        <= over_in;
      rsp_sample_ff  <= rsp_sample_in;
      rsp_ramping_ff <= rsp_ramping_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sample_out     = rsp_sample_ff;
   assign rsp_ramping        = rsp_ramping_ff;
   assign status.div_busy    = div_busy;
   assign status.ramp_active = cur_ff != tgt_ff;
   assign status.present     = present_ff;
   assign status.out_free    = out_free;

endmodule

@@ src/dgr_ctrl.sv @@
module dgr_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     csr_write_en,
   input  dgr_pkg::ctrl_status_type status,
   output dgr_pkg::ctrl_cmd_type    cmd
);
   import dgr_pkg::*;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_RAMP   = 4'd1;
   localparam logic [3:0] ST_UPD    = 4'd2;
   localparam logic [3:0] ST_LOG    = 4'd3;
   localparam logic [3:0] ST_EXP    = 4'd4;
   localparam logic [3:0] ST_TAB    = 4'd5;
   localparam logic [3:0] ST_INTERP = 4'd6;
   localparam logic [3:0] ST_MANT   = 4'd7;
   localparam logic [3:0] ST_SCALE  = 4'd8;
   localparam logic [3:0] ST_ROUND  = 4'd9;
   localparam logic [3:0] ST_OUT    = 4'd10;

   logic [3:0] state_ff, state_in;
   logic       stall;

   // hold requests off while busy, dividing or taking a register write
   assign stall     = (state_ff != ST_IDLE) || status.div_busy || csr_write_en;
   assign req_stall = stall;

   // sequencer
   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.mul_sel     = MUL_SEL_RAMP;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.accept = req_valid && !stall;
            if (cmd.accept) begin
               state_in = status.ramp_active ? ST_RAMP : ST_LOG;
            end
         end
         ST_RAMP: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_SEL_RAMP;
            state_in    = ST_UPD;
         end
         ST_UPD: begin
            cmd.gain_update = 1'b1;
            state_in        = ST_LOG;
         end
         ST_LOG: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_SEL_LOG;
            state_in    = status.present ? ST_EXP : ST_OUT;
         end
         ST_EXP: begin
            cmd.exp_load = 1'b1;
            state_in     = ST_TAB;
         end
         ST_TAB: begin
            cmd.table_load = 1'b1;
            state_in       = ST_INTERP;
         end
         ST_INTERP: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_SEL_INTERP;
            state_in    = ST_MANT;
         end
         ST_MANT: begin
            cmd.mant_load = 1'b1;
            state_in      = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_SEL_SCALE;
            state_in    = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round_load = 1'b1;
            state_in       = ST_OUT;
         end
         ST_OUT: begin
            cmd.out_load = status.out_free;
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ src/db_gain_with_linear_ramp.sv @@
// Audio gain stage with a linear ramp in the dB domain. Each request carries one signed
// sample and a present flag; each produces one response with the sample times 10^(g/20),
// rounded half away from zero and saturated to SAMPLE_BITS, or zero when the sample is
// absent, plus a flag that is high while the gain is still ramping. Gain g is signed
// Q8.8 dB. Writing target_gain_db (index 0) starts a ramp from the present gain over
// ramp_samples (index 1) requests; a length of zero applies the target at once. All four
// products of a request go through one shared 32x32 multiplier under a sequencer: ramp
// multiply and gain update while ramping, log multiply, then for a present sample the
// exponent, table, interpolation, mantissa, scale and rounding steps, then output; the
// next request is accepted after the output load. A target write with a nonzero ramp
// length runs a bit-serial divide for the ramp step, and no request is accepted during
// it. A finished response waits in an output register while the next is worked on.
module db_gain_with_linear_ramp #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [SAMPLE_BITS-1:0]          req_sample_in,
   input  logic                            req_sample_present,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [SAMPLE_BITS-1:0]          rsp_sample_out,
   output logic                            rsp_ramping,
   input  logic                            csr_write_en,
   input  logic [dgr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dgr_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import dgr_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // sequencer
   dgr_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .csr_write_en (csr_write_en),
      .status       (status),
      .cmd          (cmd)
   );

   // gain, ramp and arithmetic
   dgr_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_sample_in      (req_sample_in),
      .req_sample_present (req_sample_present),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_sample_out     (rsp_sample_out),
      .rsp_ramping        (rsp_ramping),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .cmd                (cmd),
      .status             (status)
   );

   // no request enters while the ramp step is being divided
   a_no_accept_in_divide: assert property (@(posedge clock) disable iff (reset)
      status.div_busy |-> !cmd.accept)
      else $error("request accepted during ramp step divide");

   // one request at a time through the shared multiplier
   a_single_request: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> !cmd.accept)
      else $error("back to back request acceptance");

   // a finished result always lands in the output register
   a_result_lands: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid)
      else $error("result load lost");

endmodule

@@ bench/tb_db_gain_with_linear_ramp.sv @@
module tb_db_gain_with_linear_ramp;

   localparam int               SAMPLE_W      = 24;
   localparam int               EXP2_DEPTH    = 256;
   localparam logic [63:0]      LN2_Q30_C     = 64'd744261118;
   localparam longint           LOG2_10_20_Q28 = 64'sd44586164;
   localparam logic [19:0]      RAMP_POS_MAX  = 20'hFFFFF;
   localparam longint           SAT_HI        = (64'sd1 <<< (SAMPLE_W - 1)) - 1;
   localparam int               DIRECTED_ITEMS = 24;
   localparam int               RANDOM_ITEMS  = 556;
   localparam int               STALL_LIMIT   = 4000;
   localparam int               TAIL_CYCLES   = 24;

   // indexes past the register file, writes there are dropped
   localparam logic [1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [1:0] CSR_SPARE_3 = 2'd3;

   typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample_out;
      logic                ramping;
   } gain_result_type;

   typedef struct packed {
      row_kind_type        kind;
      logic [1:0]          index;
      logic [19:0]         data;
      logic [SAMPLE_W-1:0] sample;
      logic                present;
      logic                fixed_on;
      gain_result_type     fixed;
   } step_row_type;

   logic                clock              = 1'b0;
   logic                reset              = 1'b1;
   logic                req_valid          = 1'b0;
   logic                req_stall;
   logic [SAMPLE_W-1:0] req_sample_in      = '0;
   logic                req_sample_present = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall          = 1'b0;
   logic [SAMPLE_W-1:0] rsp_sample_out;
   logic                rsp_ramping;
   logic                csr_write_en       = 1'b0;
   logic [1:0]          csr_index          = '0;
   logic [19:0]         csr_write_data     = '0;

   // gain stage model state
   logic [31:0]         exp2_lut [0:EXP2_DEPTH];
   logic signed [15:0]  gain_target = '0;
   logic [19:0]         ramp_len    = '0;
   logic signed [15:0]  gain_start  = '0;
   logic signed [15:0]  gain_now    = '0;
   logic [19:0]         ramp_pos    = '0;
   int                  ramp_slope  = 0;

   gain_result_type     scaled_q [$];
   int                  fail_count    = 0;
   int                  items_done    = 0;
   int                  send_idle_pct = 12;
   int                  rcv_stall_pct = 65;
   int                  quiet_cycles  = 0;

   db_gain_with_linear_ramp #(
      .SAMPLE_BITS(SAMPLE_W)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample_in      (req_sample_in),
      .req_sample_present (req_sample_present),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_sample_out     (rsp_sample_out),
      .rsp_ramping        (rsp_ramping),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   // clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rcv_stall_pct);
   end

   // response check against the oldest prediction
   always @(posedge clock) begin : rsp_check
      gain_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (scaled_q.size() == 0) begin
            $error("response with no request outstanding: sample_out %0d ramping %0b",
                   $signed(rsp_sample_out), rsp_ramping);
            fail_count++;
         end else begin
            want = scaled_q.pop_front();
            if (rsp_sample_out !== want.sample_out) begin
               $error("sample_out: expected %0d, got %0d",
                      $signed(want.sample_out), $signed(rsp_sample_out));
               fail_count++;
            end
            if (rsp_ramping !== want.ramping) begin
               $error("ramping: expected %0b, got %0b", want.ramping, rsp_ramping);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall)
                   || csr_write_en) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_db_gain_with_linear_ramp: FAIL");
            $finish;
         end
      end
   end

   // one sample through the gain stage: ramp advance, then 10^(g/20) scaling
   function automatic gain_result_type gain_stage_step(input logic [SAMPLE_W-1:0] s,
                                                        input logic p);
      gain_result_type res;
      int           diff;
      logic [63:0]  adiff;
      logic [63:0]  astep;
      logic [63:0]  om;
      longint       lbs;
      logic [63:0]  u;
      int           e;
      int           sh;
      logic [63:0]  frac20;
      logic [63:0]  pos;
      logic [63:0]  idx;
      logic [63:0]  wgt;
      logic [63:0]  mant;
      logic [63:0]  mag;
      logic [63:0]  r;
      longint       sv;
      longint       yv;
      // ramp advance
      if (gain_now != gain_target) begin
         diff  = int'(gain_target) - int'(gain_start);
         adiff = 64'(diff < 0 ? -diff : diff);
         astep = 64'(ramp_slope < 0 ? -ramp_slope : ramp_slope);
         if (ramp_pos < RAMP_POS_MAX) ramp_pos++;
         om = (astep * 64'(ramp_pos) + 64'd16384) >> 15;
         if (ramp_pos >= ramp_len || om >= adiff)
            gain_now = gain_target;
         else
            gain_now = 16'(int'(gain_start) + (ramp_slope < 0 ? -int'(om) : int'(om)));
      end
      res.ramping = (gain_now != gain_target);

      // gain in the log2 domain: shift from the integer part, table for the fraction
      lbs    = longint'(gain_now) * LOG2_10_20_Q28 + (64'sd32 <<< 36);
      u      = lbs;
      e      = int'(u >> 36) - 32;
      frac20 = (u & ((64'd1 << 36) - 64'd1)) >> 16;
      pos    = frac20 * EXP2_DEPTH;
      idx    = pos >> 20;
      wgt    = pos & 64'hFFFFF;
      if (idx >= EXP2_DEPTH) idx = EXP2_DEPTH - 1;
      mant = 64'(exp2_lut[idx]) +
             (((64'(exp2_lut[idx + 1]) - 64'(exp2_lut[idx])) * wgt) >> 20);

      // scale, round half away from zero, saturate
      sv  = longint'($signed(s));
      mag = (sv < 0) ? 64'(-sv) : 64'(sv);
      mag = mag * mant;
      sh  = 30 - e;
      r   = (mag + (64'd1 << (sh - 1))) >> sh;
      if (sv < 0)
         yv = (r > 64'(SAT_HI + 1)) ? -(SAT_HI + 1) : -longint'(r);
      else
         yv = (r > 64'(SAT_HI)) ? SAT_HI : longint'(r);
      res.sample_out = p ? SAMPLE_W'(yv) : '0;
      return res;
   endfunction

   function automatic step_row_type item_row(input logic [SAMPLE_W-1:0] s, input logic p);
      step_row_type row;
      row          = '0;
      row.kind     = ROW_ITEM;
      row.sample   = s;
      row.present  = p;
      return row;
   endfunction

   function automatic step_row_type fixed_row(input logic [SAMPLE_W-1:0] s, input logic p,
                                              input logic [SAMPLE_W-1:0] out,
                                              input logic ramp);
      step_row_type row;
      row                  = item_row(s, p);
      row.fixed_on         = 1'b1;
      row.fixed.sample_out = out;
      row.fixed.ramping    = ramp;
      return row;
   endfunction

   function automatic step_row_type write_row(input logic [1:0] index,
                                              input logic [19:0] data);
      step_row_type row;
      row       = '0;
      row.kind  = ROW_WRITE;
      row.index = index;
      row.data  = data;
      return row;
   endfunction

   function automatic logic [SAMPLE_W-1:0] rand_sample();
      case ($urandom_range(9))
         0:       return 24'h7FFFFF;
         1:       return 24'h800000;
         2:       return SAMPLE_W'(int'($urandom_range(0, 512)) - 256);
         3:       return '0;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic logic [19:0] pick_ramp_len();
      case ($urandom_range(9))
         0, 1:    return '0;
         2:       return 20'd1;
         3:       return RAMP_POS_MAX;
         4:       return 20'($urandom);
         5, 6:    return 20'($urandom_range(2, 16));
         default: return 20'($urandom_range(17, 200));
      endcase
   endfunction

   function automatic logic [19:0] pick_target();
      logic [15:0] t;
      case ($urandom_range(7))
         0:       t = 16'h7FFF;
         1:       t = 16'h8000;
         2:       t = '0;
         3:       t = gain_now;
         4, 5:    t = 16'(int'(gain_now) + int'($urandom_range(0, 512)) - 256);
         default: t = 16'($urandom);
      endcase
      return {{4{t[15]}}, t};
   endfunction

   // one request; the prediction is queued at acceptance
   task automatic send_item(input logic [SAMPLE_W-1:0] s, input logic p,
                            input logic fixed_on, input gain_result_type fixed);
      gain_result_type got;
      if (items_done < 210) begin
         send_idle_pct = 12;
         rcv_stall_pct = 65;
      end else if (items_done < 420) begin
         send_idle_pct = 65;
         rcv_stall_pct = 12;
      end else begin
         send_idle_pct = 0;
         rcv_stall_pct = 0;
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_sample_in      <= s;
      req_sample_present <= p;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      got = gain_stage_step(s, p);
      scaled_q.push_back(fixed_on ? fixed : got);
      items_done++;
      @(negedge clock);
   endtask

   // register write once the block has drained
   task automatic write_csr(input logic [1:0] index, input logic [19:0] data);
      int          diff;
      logic [63:0] mag;
      req_valid <= 1'b0;
      @(negedge clock);
      while (scaled_q.size() != 0) @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= index;
      csr_write_data <= data;
      case (index)
         dgr_pkg::CSR_TARGET_GAIN: begin
            gain_target = data[15:0];
            gain_start  = gain_now;
            ramp_pos    = '0;
            diff        = int'(gain_target) - int'(gain_start);
            if (ramp_len == 0) begin
               gain_now   = gain_target;
               ramp_slope = 0;
            end else begin
               mag        = (64'(diff < 0 ? -diff : diff) << 15) / ramp_len;
               ramp_slope = diff < 0 ? -int'(mag) : int'(mag);
            end
         end
         dgr_pkg::CSR_RAMP_SAMPLES: begin
            ramp_len = data;
         end
         default: begin
         end
      endcase
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   // main sequence
   initial begin : stimulus
      step_row_type plan [$];
      logic [63:0]  x;
      logic [63:0]  y;
      logic [63:0]  term;
      logic [63:0]  sum;

      // 2^(i/depth) table in Q30 by exp series
      for (int i = 0; i <= EXP2_DEPTH; i++) begin
         x    = (64'(i) << 30) / EXP2_DEPTH;
         y    = (x * LN2_Q30_C) >> 30;
         term = 64'd1 << 30;
         sum  = term;
         for (int n = 1; n <= 20; n++) begin
            term = ((term * y) >> 30) / n;
            sum  = sum + term;
         end
         exp2_lut[i] = sum[31:0];
      end

      // unity gain after reset, extremes, missing sample
      plan.push_back(fixed_row(24'h000000, 1'b1, 24'h000000, 1'b0));
      plan.push_back(fixed_row(24'h7FFFFF, 1'b1, 24'h7FFFFF, 1'b0));
      plan.push_back(fixed_row(24'h800000, 1'b1, 24'h800000, 1'b0));
      plan.push_back(fixed_row(24'h800000, 1'b0, 24'h000000, 1'b0));
      plan.push_back(fixed_row(24'h000001, 1'b1, 24'h000001, 1'b0));
      plan.push_back(fixed_row(24'hFFFFFF, 1'b1, 24'hFFFFFF, 1'b0));
      // out of range register index is dropped
      plan.push_back(write_row(CSR_SPARE_3, 20'hABCDE));
      plan.push_back(write_row(CSR_SPARE_2, 20'h54321));
      plan.push_back(fixed_row(24'h003039, 1'b1, 24'h003039, 1'b0));
      // max gain at once, saturation both ways
      plan.push_back(write_row(dgr_pkg::CSR_TARGET_GAIN, 20'h07FFF));
      plan.push_back(fixed_row(24'h7FFFFF, 1'b1, 24'h7FFFFF, 1'b0));
      plan.push_back(fixed_row(24'h800000, 1'b1, 24'h800000, 1'b0));
      plan.push_back(fixed_row(24'h000000, 1'b1, 24'h000000, 1'b0));
      // min gain at once, tiny samples round to zero
      plan.push_back(write_row(dgr_pkg::CSR_TARGET_GAIN, 20'hF8000));
      plan.push_back(fixed_row(24'h000001, 1'b1, 24'h000000, 1'b0));
      plan.push_back(fixed_row(24'hFFFFFF, 1'b1, 24'h000000, 1'b0));
      plan.push_back(item_row(24'h7FFFFF, 1'b1));
      // short ramp with a missing sample in the middle
      plan.push_back(write_row(dgr_pkg::CSR_RAMP_SAMPLES, 20'd4));
      plan.push_back(write_row(dgr_pkg::CSR_TARGET_GAIN, 20'h00000));
      plan.push_back(item_row(24'h123456, 1'b1));
      plan.push_back(item_row(24'hFFEC78, 1'b0));
      plan.push_back(item_row(24'h001E61, 1'b1));
      plan.push_back(item_row(24'hFFE19F, 1'b1));
      // same target again, no ramp
      plan.push_back(write_row(dgr_pkg::CSR_TARGET_GAIN, 20'h00000));
      plan.push_back(fixed_row(24'h000064, 1'b1, 24'h000064, 1'b0));
      // step truncates to zero, gain holds at start
      plan.push_back(write_row(dgr_pkg::CSR_RAMP_SAMPLES, 20'd40000));
      plan.push_back(write_row(dgr_pkg::CSR_TARGET_GAIN, 20'h00001));
      plan.push_back(fixed_row(24'h0003E8, 1'b1, 24'h0003E8, 1'b1));
      plan.push_back(fixed_row(24'h0003E8, 1'b1, 24'h0003E8, 1'b1));
      plan.push_back(fixed_row(24'h0003E8, 1'b1, 24'h0003E8, 1'b1));
      // length shortened mid-ramp, ends on the live length
      plan.push_back(write_row(dgr_pkg::CSR_RAMP_SAMPLES, 20'd5));
      plan.push_back(item_row(24'h0003E8, 1'b1));
      plan.push_back(item_row(24'h0003E8, 1'b1));
      // longest ramp
      plan.push_back(write_row(dgr_pkg::CSR_RAMP_SAMPLES, RAMP_POS_MAX));
      plan.push_back(write_row(dgr_pkg::CSR_TARGET_GAIN, 20'h07FFF));
      plan.push_back(item_row(24'h5A5A5A, 1'b1));

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_WRITE)
            write_csr(plan[i].index, plan[i].data);
         else
            send_item(plan[i].sample, plan[i].present, plan[i].fixed_on, plan[i].fixed);
      end

      // random phases: a new ramp length, a spare write and a new target, each at random, then a run of samples
      while (items_done < DIRECTED_ITEMS + RANDOM_ITEMS) begin
         if ($urandom_range(1) == 1)
            write_csr(dgr_pkg::CSR_RAMP_SAMPLES, pick_ramp_len());
         if ($urandom_range(9) == 0)
            write_csr(($urandom_range(1) == 1) ? CSR_SPARE_2 : CSR_SPARE_3, 20'($urandom));
         if ($urandom_range(4) != 0)
            write_csr(dgr_pkg::CSR_TARGET_GAIN, pick_target());
         repeat ($urandom_range(8, 40))
            send_item(rand_sample(), ($urandom_range(99) < 85), 1'b0, '0);
      end

      // drain and settle
      req_valid <= 1'b0;
      while (scaled_q.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("tb_db_gain_with_linear_ramp: PASS");
      end else begin
         $display("tb_db_gain_with_linear_ramp: FAIL");
      end
      $finish;
   end

endmodule
